/* rtl/lbs_pkg.sv */
// Shared constants, types and helper functions for the letterbox scaler.
`default_nettype none

package lbs_pkg;

  localparam int FRAME_WORDS     = 1048576;
  localparam int MAX_SRC_DIM     = 1024;
  localparam int SCALE_FRAC_BITS = 16;

  localparam int ADDR_W     = $clog2(FRAME_WORDS);
  localparam int PIX_IN_W   = 32;
  localparam int PIX_W      = 24;
  localparam int RGBA_W     = 32;
  localparam int COORD_W    = 12;
  localparam int VIEW_W     = 13;
  localparam int EDGE_W     = VIEW_W + 1;
  localparam int SRC_DIM_W  = 11;
  localparam int SRC_IDX_W  = $clog2(MAX_SRC_DIM);
  localparam int SCALE_W    = 24;
  localparam int MUL_W      = COORD_W + SCALE_W;
  localparam int SCALED_W   = MUL_W - SCALE_FRAC_BITS;
  localparam int MAP_W      = SRC_IDX_W + SRC_DIM_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_STEP    = 3'd6;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET   = 11'd720;
  localparam logic [SCALE_W-1:0]   SRC_STEP_RESET  = 24'd65536;
  localparam logic [7:0]           ALPHA_OPAQUE    = 8'hff;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [VIEW_W-1:0]  width;
    logic [VIEW_W-1:0]  height;
  } view_cfg_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_width;
    logic [SRC_DIM_W-1:0] src_height;
    logic [SCALE_W-1:0]   src_step;
  } map_cfg_t;

  typedef struct packed {
    logic               is_fetch;
    logic               in_view;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIX_W-1:0]   wr_pixel;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic [SRC_DIM_W-1:0] eff_dim(input logic [SRC_DIM_W-1:0] d);
    logic [SRC_DIM_W-1:0] r;
    if (d == '0) begin
      r = SRC_DIM_W'(1);
    end else if (d > SRC_DIM_W'(MAX_SRC_DIM)) begin
      r = SRC_DIM_W'(MAX_SRC_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [RGBA_W-1:0] swap_to_rgba(input logic [PIX_W-1:0] w);
    return {ALPHA_OPAQUE, w[7:0], w[15:8], w[23:16]};
  endfunction

endpackage

`default_nettype wire

/* rtl/lbs_front.sv */
// Front end: accepts input words, classifies them and computes view offsets.
`default_nettype none

module lbs_front (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_opcode,
  input  wire logic [lbs_pkg::ADDR_W-1:0]   in_write_addr,
  input  wire logic [lbs_pkg::PIX_IN_W-1:0] in_write_pixel,
  input  wire logic [lbs_pkg::COORD_W-1:0]  in_disp_x,
  input  wire logic [lbs_pkg::COORD_W-1:0]  in_disp_y,
  input  wire lbs_pkg::view_cfg_t           view_cfg,
  input  wire lbs_pkg::queue_status_t       q_status,
  output logic                              q_push,
  output lbs_pkg::cmd_t                     q_cmd
);

  logic [lbs_pkg::EDGE_W-1:0] right_edge;
  logic [lbs_pkg::EDGE_W-1:0] bottom_edge;
  logic                       in_x;
  logic                       in_y;

  assign right_edge  = lbs_pkg::EDGE_W'(view_cfg.left) + lbs_pkg::EDGE_W'(view_cfg.width);
  assign bottom_edge = lbs_pkg::EDGE_W'(view_cfg.top) + lbs_pkg::EDGE_W'(view_cfg.height);

  assign in_x = (in_disp_x >= view_cfg.left) &&
                (lbs_pkg::EDGE_W'(in_disp_x) < right_edge);
  assign in_y = (in_disp_y >= view_cfg.top) &&
                (lbs_pkg::EDGE_W'(in_disp_y) < bottom_edge);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_cmd.is_fetch = (in_opcode == lbs_pkg::OP_FETCH);
    q_cmd.in_view  = in_x && in_y;
    q_cmd.wr_addr  = in_write_addr;
    q_cmd.wr_pixel = in_write_pixel[lbs_pkg::PIX_W-1:0];
    q_cmd.off_x    = in_disp_x - view_cfg.left;
    q_cmd.off_y    = in_disp_y - view_cfg.top;
  end

endmodule

`default_nettype wire

/* rtl/lbs_queue.sv */
// Short command queue between the front end and the back end.
`default_nettype none

module lbs_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire lbs_pkg::cmd_t          push_cmd,
  input  wire logic                   pop,
  output lbs_pkg::cmd_t               head_cmd,
  output lbs_pkg::queue_status_t      status
);

  lbs_pkg::cmd_t               entry_r [lbs_pkg::QUEUE_DEPTH];
  logic [lbs_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lbs_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lbs_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == lbs_pkg::QCNT_W'(lbs_pkg::QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lbs_pkg::QPTR_W'(lbs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + lbs_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lbs_pkg::QPTR_W'(lbs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + lbs_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + lbs_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - lbs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/lbs_back.sv */
// Back end: source frame memory, coordinate mapping and result register.
`default_nettype none

module lbs_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lbs_pkg::map_cfg_t           map_cfg,
  input  wire lbs_pkg::cmd_t               q_cmd,
  input  wire lbs_pkg::queue_status_t      q_status,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lbs_pkg::RGBA_W-1:0]       out_rgba_pixel,
  output logic                             out_inside_view
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [lbs_pkg::PIX_W-1:0]     frame_mem [lbs_pkg::FRAME_WORDS];

  logic [2:0]                    state_r, state_nxt;
  logic [lbs_pkg::COORD_W-1:0]   off_x_r, off_y_r;
  logic                          inside_r;
  logic [lbs_pkg::MUL_W-1:0]     prod_x_r, prod_y_r;
  logic [lbs_pkg::MAP_W-1:0]     addr_r;
  logic                          addr_ok_r;
  logic [lbs_pkg::PIX_W-1:0]     rd_data_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [lbs_pkg::RGBA_W-1:0]    out_pixel_r;
  logic                          out_inside_r;

  logic [lbs_pkg::SRC_DIM_W-1:0] w_eff, h_eff, w_last, h_last;
  logic [lbs_pkg::SCALED_W-1:0]  scaled_x, scaled_y;
  logic [lbs_pkg::SRC_IDX_W-1:0] sx, sy;
  logic [lbs_pkg::MAP_W-1:0]     map_addr;
  logic                          mem_we;
  logic                          load_out;
  logic [lbs_pkg::RGBA_W-1:0]    result_pixel;

  assign w_eff  = lbs_pkg::eff_dim(map_cfg.src_width);
  assign h_eff  = lbs_pkg::eff_dim(map_cfg.src_height);
  assign w_last = w_eff - lbs_pkg::SRC_DIM_W'(1);
  assign h_last = h_eff - lbs_pkg::SRC_DIM_W'(1);

  assign scaled_x = prod_x_r[lbs_pkg::MUL_W-1:lbs_pkg::SCALE_FRAC_BITS];
  assign scaled_y = prod_y_r[lbs_pkg::MUL_W-1:lbs_pkg::SCALE_FRAC_BITS];
  assign sx = (scaled_x > lbs_pkg::SCALED_W'(w_last)) ? w_last[lbs_pkg::SRC_IDX_W-1:0] :
              scaled_x[lbs_pkg::SRC_IDX_W-1:0];
  assign sy = (scaled_y > lbs_pkg::SCALED_W'(h_last)) ? h_last[lbs_pkg::SRC_IDX_W-1:0] :
              scaled_y[lbs_pkg::SRC_IDX_W-1:0];
  assign map_addr = lbs_pkg::MAP_W'(sy) * lbs_pkg::MAP_W'(w_eff) + lbs_pkg::MAP_W'(sx);

  assign q_pop    = (state_r == ST_IDLE) && !q_status.empty;
  assign mem_we   = q_pop && !q_cmd.is_fetch;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  assign result_pixel = !inside_r ? '0 :
                        lbs_pkg::swap_to_rgba(addr_ok_r ? rd_data_r : '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.is_fetch) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_fetch) begin
      off_x_r  <= q_cmd.off_x;
      off_y_r  <= q_cmd.off_y;
      inside_r <= q_cmd.in_view;
    end
    if (state_r == ST_MUL) begin
      prod_x_r <= lbs_pkg::MUL_W'(off_x_r) * lbs_pkg::MUL_W'(map_cfg.src_step);
      prod_y_r <= lbs_pkg::MUL_W'(off_y_r) * lbs_pkg::MUL_W'(map_cfg.src_step);
    end
    if (state_r == ST_ADDR) begin
      addr_r    <= map_addr;
      addr_ok_r <= map_addr < lbs_pkg::MAP_W'(lbs_pkg::FRAME_WORDS);
    end
    if (load_out) begin
      out_pixel_r  <= result_pixel;
      out_inside_r <= inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[q_cmd.wr_addr] <= q_cmd.wr_pixel;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= frame_mem[addr_r[lbs_pkg::ADDR_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rgba_pixel  = out_pixel_r;
  assign out_inside_view = out_inside_r;

endmodule

`default_nettype wire

/* rtl/letterbox_nearest_scaler_core.sv */
// Top level of the letterbox nearest-neighbor scaler with its register bank.
//
// The block stores a source frame of 24-bit pixels and answers display
// fetches with the nearest source pixel as RGBA, or zero outside the view.
// A front end accepts words and classifies them into a two-entry queue; a
// back-end sequencer takes one queued word at a time. A write word is
// stored as the back end pops it; a fetch steps through offset multiply,
// clamp and address multiply, frame read and result load before another
// word is taken, so fetch throughput is set by the back-end sequencer and
// its single frame port. The result register lets a new word enter while a
// result waits. The frame memory is not cleared at reset: a fetch that lands
// on a location never written returns an arbitrary color. Registers must be
// written only while the block is idle; the block does not enforce it.
`default_nettype none

module letterbox_nearest_scaler_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_opcode,
  input  wire logic [lbs_pkg::ADDR_W-1:0]      in_write_addr,
  input  wire logic [lbs_pkg::PIX_IN_W-1:0]    in_write_pixel,
  input  wire logic [lbs_pkg::COORD_W-1:0]     in_disp_x,
  input  wire logic [lbs_pkg::COORD_W-1:0]     in_disp_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lbs_pkg::RGBA_W-1:0]           out_rgba_pixel,
  output logic                                 out_inside_view
);

  lbs_pkg::view_cfg_t      view_cfg_r;
  lbs_pkg::map_cfg_t       map_cfg_r;
  lbs_pkg::cmd_t           push_cmd;
  lbs_pkg::cmd_t           head_cmd;
  lbs_pkg::queue_status_t  q_status;
  logic                    q_push;
  logic                    q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cfg_r.src_width  <= lbs_pkg::SRC_DIM_RESET;
      map_cfg_r.src_height <= lbs_pkg::SRC_DIM_RESET;
      map_cfg_r.src_step   <= lbs_pkg::SRC_STEP_RESET;
      view_cfg_r.left      <= '0;
      view_cfg_r.top       <= '0;
      view_cfg_r.width     <= '0;
      view_cfg_r.height    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbs_pkg::CFG_SRC_WIDTH:   map_cfg_r.src_width  <= cfg_wdata[lbs_pkg::SRC_DIM_W-1:0];
        lbs_pkg::CFG_SRC_HEIGHT:  map_cfg_r.src_height <= cfg_wdata[lbs_pkg::SRC_DIM_W-1:0];
        lbs_pkg::CFG_VIEW_LEFT:   view_cfg_r.left      <= cfg_wdata[lbs_pkg::COORD_W-1:0];
        lbs_pkg::CFG_VIEW_TOP:    view_cfg_r.top       <= cfg_wdata[lbs_pkg::COORD_W-1:0];
        lbs_pkg::CFG_VIEW_WIDTH:  view_cfg_r.width     <= cfg_wdata[lbs_pkg::VIEW_W-1:0];
        lbs_pkg::CFG_VIEW_HEIGHT: view_cfg_r.height    <= cfg_wdata[lbs_pkg::VIEW_W-1:0];
        lbs_pkg::CFG_SRC_STEP:    map_cfg_r.src_step   <= cfg_wdata[lbs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  lbs_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_write_addr  (in_write_addr),
    .in_write_pixel (in_write_pixel),
    .in_disp_x      (in_disp_x),
    .in_disp_y      (in_disp_y),
    .view_cfg       (view_cfg_r),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  lbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  lbs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .map_cfg         (map_cfg_r),
    .q_cmd           (head_cmd),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rgba_pixel  (out_rgba_pixel),
    .out_inside_view (out_inside_view)
  );

endmodule

`default_nettype wire

/* rtl/lbs_checker.sv */
// Port-level checks for the letterbox scaler, bound to its top level.
`default_nettype none

module lbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_rgba_pixel,
  input wire logic        out_inside_view
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rgba_pixel) && $stable(out_inside_view))
    else $error("result word changed while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_view |-> out_rgba_pixel == 32'h0)
    else $error("pixel outside the view is not zero");

  a_inside_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_view |-> out_rgba_pixel[31:24] == 8'hff)
    else $error("pixel inside the view is not opaque");

endmodule

bind letterbox_nearest_scaler_core lbs_checker u_lbs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rgba_pixel  (out_rgba_pixel),
  .out_inside_view (out_inside_view)
);

`default_nettype wire

/* verif/tb_letterbox_nearest_scaler_core.sv */
// Self-checking testbench for the letterbox nearest-neighbor scaler core.
`timescale 1ns / 1ps

module tb_letterbox_nearest_scaler_core;

  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [lbs_pkg::RGBA_W-1:0] rgba;
    logic                       in_view;
  } fetch_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_FETCH, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [lbs_pkg::ADDR_W-1:0]  num;
    logic [31:0]                 data;
    logic [lbs_pkg::COORD_W-1:0] x;
    logic [lbs_pkg::COORD_W-1:0] y;
    logic                        typed;
    fetch_result_t               res;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [lbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_opcode = lbs_pkg::OP_WRITE;
  logic [lbs_pkg::ADDR_W-1:0]     in_write_addr = '0;
  logic [lbs_pkg::PIX_IN_W-1:0]   in_write_pixel = '0;
  logic [lbs_pkg::COORD_W-1:0]    in_disp_x = '0;
  logic [lbs_pkg::COORD_W-1:0]    in_disp_y = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [lbs_pkg::RGBA_W-1:0]     out_rgba_pixel;
  logic                           out_inside_view;

  logic [lbs_pkg::PIX_W-1:0]  frame_copy [int unsigned];
  int unsigned                reg_copy [8];
  fetch_result_t              pending_pixels [$];

  bit in_gaps = 1'b0;
  bit out_idling = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int words_in = 0;
  int results_seen = 0;
  int reg_writes = 0;

  letterbox_nearest_scaler_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_write_addr  (in_write_addr),
    .in_write_pixel (in_write_pixel),
    .in_disp_x      (in_disp_x),
    .in_disp_y      (in_disp_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rgba_pixel (out_rgba_pixel),
    .out_inside_view(out_inside_view)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned d);
    if (d == 0) return 1;
    if (d > lbs_pkg::MAX_SRC_DIM) return lbs_pkg::MAX_SRC_DIM;
    return d;
  endfunction

  function automatic int unsigned map_offset(input int unsigned off, input int unsigned dim);
    longint unsigned s;
    s = (longint'(off) * longint'(reg_copy[lbs_pkg::CFG_SRC_STEP])) >> lbs_pkg::SCALE_FRAC_BITS;
    if (s > longint'(dim - 1)) return dim - 1;
    return int'(s);
  endfunction

  // Return whether (x, y) falls in the view and, if so, the source word it reads.
  function automatic bit locate_source(input logic [lbs_pkg::COORD_W-1:0] x,
                                       input logic [lbs_pkg::COORD_W-1:0] y,
                                       output int unsigned addr);
    int unsigned w;
    int unsigned h;
    int unsigned vl;
    int unsigned vt;
    bit hit;
    vl = reg_copy[lbs_pkg::CFG_VIEW_LEFT];
    vt = reg_copy[lbs_pkg::CFG_VIEW_TOP];
    hit = (x >= vl) && (x < vl + reg_copy[lbs_pkg::CFG_VIEW_WIDTH]) &&
          (y >= vt) && (y < vt + reg_copy[lbs_pkg::CFG_VIEW_HEIGHT]);
    addr = 0;
    if (hit) begin
      w = clamp_dim(reg_copy[lbs_pkg::CFG_SRC_WIDTH]);
      h = clamp_dim(reg_copy[lbs_pkg::CFG_SRC_HEIGHT]);
      addr = map_offset(y - vt, h) * w + map_offset(x - vl, w);
    end
    return hit;
  endfunction

  function automatic plan_row_t mk(input row_kind_t kind, input int unsigned num,
                                   input logic [31:0] data, input int unsigned x,
                                   input int unsigned y, input bit typed,
                                   input logic [31:0] rgba, input bit in_view);
    plan_row_t r;
    r.kind = kind;
    r.num = lbs_pkg::ADDR_W'(num);
    r.data = data;
    r.x = lbs_pkg::COORD_W'(x);
    r.y = lbs_pkg::COORD_W'(y);
    r.typed = typed;
    r.res.rgba = rgba;
    r.res.in_view = in_view;
    return r;
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0: return lbs_pkg::MAX_SRC_DIM;
      1: return 0;
      2: return $urandom_range(lbs_pkg::MAX_SRC_DIM + 1, 2047);
      3: return $urandom_range(1, lbs_pkg::MAX_SRC_DIM);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_origin();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(3900, 4095);
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(1, 4096);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [lbs_pkg::COORD_W-1:0] pick_coord(input int unsigned origin,
                                                             input int unsigned span);
    if ($urandom_range(0, 3) == 0) return lbs_pkg::COORD_W'($urandom);
    return lbs_pkg::COORD_W'(origin + $urandom_range(0, span + 1) - 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [lbs_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    int unsigned bits;
    int unsigned mask;
    case (idx) inside
      lbs_pkg::CFG_SRC_WIDTH, lbs_pkg::CFG_SRC_HEIGHT:   bits = 11;
      lbs_pkg::CFG_VIEW_LEFT, lbs_pkg::CFG_VIEW_TOP:     bits = 12;
      lbs_pkg::CFG_VIEW_WIDTH, lbs_pkg::CFG_VIEW_HEIGHT: bits = 13;
      default: bits = 24;
    endcase
    mask = (32'd1 << bits) - 1;
    reg_copy[idx] = val & mask;
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = lbs_pkg::CFG_DATA_W'(($urandom & ~mask) | (val & mask));
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_word(input logic op, input logic [lbs_pkg::ADDR_W-1:0] addr,
                           input logic [lbs_pkg::PIX_IN_W-1:0] pixel,
                           input logic [lbs_pkg::COORD_W-1:0] x,
                           input logic [lbs_pkg::COORD_W-1:0] y, input bit typed,
                           input fetch_result_t typed_res);
    int unsigned gap;
    int unsigned a;
    fetch_result_t res;
    logic [lbs_pkg::PIX_W-1:0] word;
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) begin
        in_opcode = 1'($urandom);
        in_write_addr = lbs_pkg::ADDR_W'($urandom);
        in_write_pixel = $urandom;
        in_disp_x = lbs_pkg::COORD_W'($urandom);
        in_disp_y = lbs_pkg::COORD_W'($urandom);
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_opcode = op;
    in_write_addr = addr;
    in_write_pixel = pixel;
    in_disp_x = x;
    in_disp_y = y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    if (op == lbs_pkg::OP_WRITE) begin
      frame_copy[addr] = pixel[lbs_pkg::PIX_W-1:0];
    end else begin
      res = '0;
      if (locate_source(x, y, a)) begin
        word = (a < lbs_pkg::FRAME_WORDS && frame_copy.exists(a)) ? frame_copy[a] : '0;
        res.rgba = {lbs_pkg::ALPHA_OPAQUE, word[7:0], word[15:8], word[23:16]};
        res.in_view = 1'b1;
      end
      pending_pixels.push_back(typed ? typed_res : res);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_idling && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    fetch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", out_rgba_pixel, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_rgba_pixel !== want.rgba)
          report_mismatch("rgba_pixel", out_rgba_pixel, want.rgba);
        if (out_inside_view !== want.in_view)
          report_mismatch("inside_view", 32'(out_inside_view), 32'(want.in_view));
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t row;
    int unsigned a;
    int unsigned w;
    int unsigned h;
    int n;
    int random_items;
    int phases;
    logic [lbs_pkg::COORD_W-1:0] x;
    logic [lbs_pkg::COORD_W-1:0] y;

    reg_copy = '{default: 0};
    reg_copy[lbs_pkg::CFG_SRC_WIDTH] = lbs_pkg::SRC_DIM_RESET;
    reg_copy[lbs_pkg::CFG_SRC_HEIGHT] = lbs_pkg::SRC_DIM_RESET;
    reg_copy[lbs_pkg::CFG_SRC_STEP] = lbs_pkg::SRC_STEP_RESET;
    random_items = 0;
    phases = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    plan = '{
      mk(ROW_FETCH, 0, 0, 0, 0, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 4095, 4095, 1, 32'h0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_WIDTH, 2, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_HEIGHT, 2, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_LEFT, 10, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_TOP, 20, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_WIDTH, 4, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_HEIGHT, 4, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_STEP, 'h8000, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 0, 32'hAABBCCDD, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 1, 32'hFFFFFFFF, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 2, 32'h00000000, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 3, 32'h00FF00FF, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 'hFFFFF, 32'h7F80C3A5, 0, 0, 0, 0, 0),
      mk(ROW_WRITE, 'hFFC00, 32'h01234567, 0, 0, 0, 0, 0),
      mk(ROW_FETCH, 0, 0, 10, 20, 1, 32'hFFDDCCBB, 1),
      mk(ROW_FETCH, 0, 0, 9, 20, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 14, 20, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 10, 24, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 10, 19, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 13, 23, 1, 32'hFFFF00FF, 1),
      mk(ROW_FETCH, 0, 0, 12, 20, 1, 32'hFFFFFFFF, 1),
      mk(ROW_FETCH, 0, 0, 10, 22, 1, 32'hFF000000, 1),
      mk(ROW_FETCH, 0, 0, 11, 21, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_WIDTH, lbs_pkg::MAX_SRC_DIM, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_HEIGHT, lbs_pkg::MAX_SRC_DIM, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_LEFT, 0, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_TOP, 0, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_WIDTH, 4096, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_HEIGHT, 4096, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_STEP, 'hFFFFFF, 0, 0, 0, 0, 0),
      mk(ROW_FETCH, 0, 0, 4095, 4095, 1, 32'hFFA5C380, 1),
      mk(ROW_FETCH, 0, 0, 0, 0, 1, 32'hFFDDCCBB, 1),
      mk(ROW_FETCH, 0, 0, 0, 4095, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_WIDTH, 0, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_HEIGHT, 2047, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_LEFT, 4000, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_VIEW_TOP, 4000, 0, 0, 0, 0, 0),
      mk(ROW_REG, lbs_pkg::CFG_SRC_STEP, 1, 0, 0, 0, 0, 0),
      mk(ROW_FETCH, 0, 0, 4095, 4095, 1, 32'hFFDDCCBB, 1),
      mk(ROW_FETCH, 0, 0, 3999, 4000, 1, 32'h0, 0),
      mk(ROW_FETCH, 0, 0, 4000, 4095, 0, 0, 0)
    };

    in_gaps = 1'b1;
    out_idling = 1'b1;
    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_REG: begin
          drain_block();
          write_reg(row.num[lbs_pkg::CFG_IDX_W-1:0], row.data);
        end
        ROW_WRITE: begin
          push_word(lbs_pkg::OP_WRITE, row.num, row.data, lbs_pkg::COORD_W'($urandom),
                    lbs_pkg::COORD_W'($urandom), 1'b0, '0);
        end
        default: begin
          push_word(lbs_pkg::OP_FETCH, lbs_pkg::ADDR_W'($urandom), $urandom, row.x, row.y,
                    row.typed, row.res);
        end
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      drain_block();
      phases++;
      write_reg(lbs_pkg::CFG_SRC_WIDTH, pick_dim());
      write_reg(lbs_pkg::CFG_SRC_HEIGHT, pick_dim());
      write_reg(lbs_pkg::CFG_VIEW_LEFT, pick_origin());
      write_reg(lbs_pkg::CFG_VIEW_TOP, pick_origin());
      write_reg(lbs_pkg::CFG_VIEW_WIDTH, pick_span());
      write_reg(lbs_pkg::CFG_VIEW_HEIGHT, pick_span());
      case ($urandom_range(0, 7))
        0: write_reg(lbs_pkg::CFG_SRC_STEP, 'h10000);
        1: write_reg(lbs_pkg::CFG_SRC_STEP, 'h8000);
        2: write_reg(lbs_pkg::CFG_SRC_STEP, 'hFFFFFF);
        3: write_reg(lbs_pkg::CFG_SRC_STEP, 1);
        4: write_reg(lbs_pkg::CFG_SRC_STEP, $urandom_range(1, 'hFFFFFF));
        default: write_reg(lbs_pkg::CFG_SRC_STEP, $urandom_range('h2000, 'h30000));
      endcase
      // drop all idling in the closing stretch
      if (random_items >= RANDOM_ITEMS - PHASE_ITEMS) begin
        in_gaps = 1'b0;
        out_idling = 1'b0;
      end else begin
        in_gaps = ($urandom_range(0, 3) != 0);
        out_idling = ($urandom_range(0, 3) != 0);
      end
      w = clamp_dim(reg_copy[lbs_pkg::CFG_SRC_WIDTH]);
      h = clamp_dim(reg_copy[lbs_pkg::CFG_SRC_HEIGHT]);
      n = 0;
      while (n < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 3) == 0) a = $urandom & (lbs_pkg::FRAME_WORDS - 1);
          else a = $urandom_range(0, h - 1) * w + $urandom_range(0, w - 1);
          push_word(lbs_pkg::OP_WRITE, lbs_pkg::ADDR_W'(a), $urandom,
                    lbs_pkg::COORD_W'($urandom), lbs_pkg::COORD_W'($urandom), 1'b0, '0);
          n++;
        end else begin
          x = pick_coord(reg_copy[lbs_pkg::CFG_VIEW_LEFT], reg_copy[lbs_pkg::CFG_VIEW_WIDTH]);
          y = pick_coord(reg_copy[lbs_pkg::CFG_VIEW_TOP], reg_copy[lbs_pkg::CFG_VIEW_HEIGHT]);
          // fill the source word first so no fetch reads unwritten frame memory
          if (locate_source(x, y, a) && !frame_copy.exists(a)) begin
            push_word(lbs_pkg::OP_WRITE, lbs_pkg::ADDR_W'(a), $urandom,
                      lbs_pkg::COORD_W'($urandom), lbs_pkg::COORD_W'($urandom), 1'b0, '0);
            n++;
          end
          push_word(lbs_pkg::OP_FETCH, lbs_pkg::ADDR_W'($urandom), $urandom, x, y, 1'b0, '0);
          n++;
        end
      end
      random_items += n;
    end

    drain_block();
    $display("ran %0d words (%0d random) across %0d random settings, %0d register writes",
             words_in, random_items, phases, reg_writes);
    $display("compared %0d fetch results, %0d source words written",
             results_seen, frame_copy.num());
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
